FILE: hw/rtl/vas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vas_pkg
// Types and constants of the voice allocator with stealing.
// ----------------------------------------------------------------------------
package vas_pkg;

  // One voice status entry as it is kept in the voice table.
  typedef struct packed {
    logic        master_slave;
    logic        looped;
    logic [13:0] loudness;
    logic        mixer_active;
    logic        kick_idle;
  } voice_entry_t;

  localparam int ENTRY_W = $bits(voice_entry_t);

  localparam int VOL_W   = 14;
  localparam int PRI_W   = 17;
  localparam int VOICE_W = 5;
  localparam int NUSE_W  = 6;

  // Input beat kinds carried on tuser.
  localparam logic CMD_UPDATE   = 1'b0;
  localparam logic CMD_ALLOCATE = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_VOICES_IN_USE = 1'b0;
  localparam logic CFG_STEAL_LIMIT   = 1'b1;

  localparam logic [NUSE_W-1:0] VOICES_IN_USE_RST = 6'd32;
  localparam logic [PRI_W-1:0]  STEAL_LIMIT_RST   = 17'(8000 * 7);

endpackage

FILE: hw/rtl/vas_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vas_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vas_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/voice_allocator_with_stealing_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_allocator_with_stealing_unit
// Voice status table with a scanning allocator that may steal a quiet voice.
// ----------------------------------------------------------------------------
// An update beat writes one voice entry and produces no result. An allocate
// beat scans the table through the single read port of the voice RAM, one
// entry per cycle, over the first n entries, where n is voices_in_use capped at
// VOICE_SLOTS; with none in use the scan is skipped. The result is registered
// after the scan, drain and done states. A stalled output holds the
// allocator in its done state until the previous result has left. Free voices
// and steal candidates are found in the same pass. Table entries carry valid
// bits that reset clears, so the table reads as all zero right after reset
// without any clearing pass. Input is taken while a previous result still
// waits on the output register.
module voice_allocator_with_stealing_unit
  import vas_pkg::*;
#(
  parameter int VOICE_SLOTS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input stream.
  input  logic                in_tvalid,
  output logic                in_tready,
  // tdata, from bit 0: voice_index[4:0], kick_idle, mixer_active,
  // loudness[13:0], looped, master_slave, one zero pad bit.
  input  logic [23:0]         in_tdata,
  // tuser: command.
  input  logic                in_tuser,
  // Result stream.
  output logic                out_tvalid,
  input  logic                out_tready,
  // tdata, from bit 0: chosen_voice[4:0], three zero pad bits.
  output logic [7:0]          out_tdata,
  // tuser: no_voice.
  output logic                out_tuser,
  // Configuration writes.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [PRI_W-1:0]    cfg_data
);

  localparam int IDX_W = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam int CW    = $clog2(VOICE_SLOTS + 1);
  localparam int LIM_W = (CW > NUSE_W) ? CW : NUSE_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // Input field unpacking.
  logic [VOICE_W-1:0] in_voice_index;
  voice_entry_t       in_entry;

  assign in_voice_index         = in_tdata[4:0];
  assign in_entry.kick_idle     = in_tdata[5];
  assign in_entry.mixer_active  = in_tdata[6];
  assign in_entry.loudness      = in_tdata[20:7];
  assign in_entry.looped        = in_tdata[21];
  assign in_entry.master_slave  = in_tdata[22];

  logic [1:0]             state_r, state_nxt;
  logic [NUSE_W-1:0]      voices_in_use_r;
  logic [PRI_W-1:0]       steal_limit_r;
  logic [VOICE_SLOTS-1:0] valid_r;
  logic [LIM_W-1:0]       n_r, n_nxt;
  logic [IDX_W-1:0]       cnt_r, cnt_nxt;
  logic                   dv_r;
  logic                   vbit_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic                   free_found_r, free_found_nxt;
  logic [IDX_W-1:0]       free_idx_r, free_idx_nxt;
  logic                   best_found_r, best_found_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [PRI_W-1:0]       best_pri_r, best_pri_nxt;
  logic                   out_tvalid_r;
  logic [VOICE_W-1:0]     out_voice_r;
  logic                   out_none_r;

  logic                   in_acc;
  logic                   upd_we;
  logic                   rd_en;
  logic [ENTRY_W-1:0]     rd_raw;
  voice_entry_t           rd_entry;
  logic                   cand_idle;
  logic                   cand_free;
  logic [PRI_W-1:0]       cand_pri;
  logic                   out_free;
  logic                   last_rd;
  logic                   res_none;
  logic [IDX_W-1:0]       res_idx;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign upd_we    = in_acc && (in_tuser == CMD_UPDATE) &&
                     (32'(in_voice_index) < VOICE_SLOTS);
  assign rd_en     = (state_r == ST_SCAN);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;
  assign last_rd   = (LIM_W'(cnt_r) == n_r - LIM_W'(1));

  vas_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(VOICE_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (upd_we),
    .waddr(IDX_W'(in_voice_index)),
    .wdata(in_entry),
    .re   (rd_en),
    .raddr(cnt_r),
    .rdata(rd_raw)
  );

  // A never-written entry reads as zero, which makes it neither idle nor free.
  always_comb begin
    rd_entry  = vbit_r ? voice_entry_t'(rd_raw) : '0;
    cand_idle = dv_r && rd_entry.kick_idle;
    cand_free = cand_idle && !rd_entry.mixer_active;
    cand_pri  = PRI_W'(rd_entry.loudness);
    if (rd_entry.looped) begin
      cand_pri = cand_pri << 1;
    end
    if (rd_entry.master_slave) begin
      cand_pri = cand_pri << 2;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    cnt_nxt        = cnt_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_pri_nxt   = best_pri_r;

    if (cand_free && !free_found_r) begin
      free_found_nxt = 1'b1;
      free_idx_nxt   = rd_idx_r;
    end
    if (cand_idle && (!best_found_r || cand_pri < best_pri_r)) begin
      best_found_nxt = 1'b1;
      best_idx_nxt   = rd_idx_r;
      best_pri_nxt   = cand_pri;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == CMD_ALLOCATE)) begin
          if (32'(voices_in_use_r) > VOICE_SLOTS) begin
            n_nxt = LIM_W'(VOICE_SLOTS);
          end else begin
            n_nxt = LIM_W'(voices_in_use_r);
          end
          cnt_nxt        = '0;
          free_found_nxt = 1'b0;
          best_found_nxt = 1'b0;
          state_nxt      = (voices_in_use_r == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (last_rd) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_none = 1'b0;
    res_idx  = free_idx_r;
    if (!free_found_r) begin
      res_idx = best_idx_r;
      if (!best_found_r || best_pri_r > steal_limit_r) begin
        res_none = 1'b1;
        res_idx  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      voices_in_use_r <= VOICES_IN_USE_RST;
      steal_limit_r   <= STEAL_LIMIT_RST;
      valid_r         <= '0;
      dv_r            <= 1'b0;
      out_tvalid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= rd_en;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_VOICES_IN_USE) begin
          voices_in_use_r <= cfg_data[NUSE_W-1:0];
        end else begin
          steal_limit_r <= cfg_data;
        end
      end
      if (upd_we) begin
        valid_r[IDX_W'(in_voice_index)] <= 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    cnt_r        <= cnt_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    best_found_r <= best_found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_pri_r   <= best_pri_nxt;
    if (rd_en) begin
      vbit_r   <= valid_r[cnt_r];
      rd_idx_r <= cnt_r;
    end
    if (state_r == ST_DONE && out_free) begin
      out_voice_r <= VOICE_W'(res_idx);
      out_none_r  <= res_none;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_voice_r};
  assign out_tuser  = out_none_r;

  // A result appears only after an allocation has finished its scan.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the done state");

  // A refused allocation always reports voice zero.
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_none_r) |-> out_voice_r == '0)
    else $error("no_voice result carries a nonzero voice");

  // A granted voice lies inside the table.
  a_voice_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_none_r) |-> 32'(out_voice_r) < VOICE_SLOTS)
    else $error("granted voice beyond the table");

  // The read pipe only carries data while a scan is in progress.
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> ($past(state_r) == ST_SCAN) &&
             (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("table read data outside a scan");

endmodule
